[src/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and byte functions for the AES-128 core
// S-box table, xtime, round transforms and key-schedule step
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds    = 10;
  localparam int unsigned NumRoundKeys = 11;
  localparam int unsigned CfgIdxW      = 1;

  typedef logic [127:0] blk_t;
  typedef logic [63:0]  half_t;
  typedef logic [7:0]   byte_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [NumRoundKeys] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i sits in bits 127-8i downto 120-8i
  function automatic byte_t get_byte(blk_t b, int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes and shiftrows
  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix(blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      t[119-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[111-32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
      t[103-32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key from the previous one
  function automatic blk_t key_step(blk_t p, byte_t rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = p[127:96];
    w1 = p[95:64];
    w2 = p[63:32];
    w3 = p[31:0];
    tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

[src/aes_if.sv]
// ----------------------------------------------------------------------------
// aes_if: valid/ready channel interfaces
// block channel with two 64-bit halves, and a configuration write channel
// ----------------------------------------------------------------------------
interface aes_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/aes_round.sv]
// ----------------------------------------------------------------------------
// aes_round: one registered cipher round
// applies one round to the state and steps the round key alongside it
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; #(
  parameter int unsigned Round = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  blk_t state_i,
  input  blk_t key_i,
  output logic valid_o,
  output blk_t state_o,
  output blk_t key_o
);

  blk_t rkey, sdata, state_d, state_q, key_q;
  logic valid_q;

  // round key for this round and the round transform
  assign rkey  = key_step(key_i, RCON[Round]);
  assign sdata = sub_shift(state_i);
  assign state_d = ((Round == NumRounds) ? sdata : mix(sdata)) ^ rkey;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= rkey;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

[src/aes128_block_encrypt_core.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core: pipelined AES-128 ECB encryption
// ----------------------------------------------------------------------------
// Usage:
//   in_blk  : plaintext word, data_high holds bytes 0..7 (byte 0 on top)
//   out_blk : ciphertext word in the same byte order
//   cfg     : index 0 writes key bytes 0..7, index 1 key bytes 8..15
// The key must be written only while the core is idle; the core does not
// enforce this. Each word carries its own round key down the pipe, so a
// word sees the key present at entry. One input register (initial key add)
// plus ten round registers, with one full round of logic between registers;
// throughput one word per cycle while out ready is not holding the pipe.
// When out ready is low with a word waiting at the output, the whole pipe
// holds and in ready drops with it, empty stages included.
// Reset clears all valid bits and sets the key to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core import aes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  aes_blk_if.sink   in_blk,
  aes_blk_if.source out_blk,
  aes_cfg_if.sink   cfg
);

  half_t key_high_q, key_low_q;
  logic  en;
  logic  vld  [NumRoundKeys];
  blk_t  st   [NumRoundKeys];
  blk_t  ky   [NumRoundKeys];
  logic  v0_q;
  blk_t  s0_q, k0_q;

  // key registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_KEY_HIGH: key_high_q <= cfg.data;
        REG_KEY_LOW:  key_low_q  <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipe advances unless the last word is stalled
  assign en           = !vld[NumRounds] || out_blk.ready;
  assign in_blk.ready = en;

  // entry stage: initial key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_blk.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= {in_blk.data_high, in_blk.data_low} ^ {key_high_q, key_low_q};
      k0_q <= {key_high_q, key_low_q};
    end
  end
  assign vld[0] = v0_q;
  assign st[0]  = s0_q;
  assign ky[0]  = k0_q;

  // ten round stages
  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(.Round(r)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[r-1]),
      .state_i (st[r-1]),
      .key_i   (ky[r-1]),
      .valid_o (vld[r]),
      .state_o (st[r]),
      .key_o   (ky[r])
    );
  end

  assign out_blk.valid     = vld[NumRounds];
  assign out_blk.data_high = st[NumRounds][127:64];
  assign out_blk.data_low  = st[NumRounds][63:0];

  // a stalled word stays valid and keeps its low half
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_blk.valid && !out_blk.ready |=> out_blk.valid && $stable(out_blk.data_low))
    else $error("stalled output changed");
  // ready only drops while the output stalls
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_blk.ready |-> out_blk.valid && !out_blk.ready)
    else $error("input blocked without output stall");
  // accepted word reaches the first stage
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_blk.valid && in_blk.ready |=> v0_q)
    else $error("accepted word lost");

endmodule

[test/tb_aes128_block_encrypt_core.sv]
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_core: self-checking bench for the AES-128 ECB core
// drives plaintext words under several idle and stall mixes, predicts every
// ciphertext with an independent cipher model and compares in order
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_core;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeDepth = 11;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  aes_blk_if in_blk ();
  aes_blk_if out_blk ();
  aes_cfg_if cfg ();

  aes128_block_encrypt_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_blk (in_blk.sink),
    .out_blk(out_blk.source),
    .cfg    (cfg.sink)
  );

  always #6 clk_i = ~clk_i;

  // model copy of the key registers
  logic [63:0]  key_hi_q = '0;
  logic [63:0]  key_lo_q = '0;
  cipher_word_t cipher_fifo[$];
  int unsigned  n_errors    = 0;
  int unsigned  send_idle   = 0;  // percent chance of an idle cycle
  int unsigned  sink_stall  = 0;
  bit           hold_off    = 1'b0;

  // local galois helper; the s-box comes from aes_pkg
  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] pt);
    logic [7:0]   st[16];
    logic [7:0]   tmp[16];
    logic [7:0]   rk[16];
    logic [7:0]   rc;
    logic [7:0]   t0, t1, t2, t3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      // next round key
      t0 = SBOX[rk[13]] ^ rc;
      t1 = SBOX[rk[14]];
      t2 = SBOX[rk[15]];
      t3 = SBOX[rk[12]];
      rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = gf_dbl(rc);
      // substitute and rotate rows
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) tmp[4*c+w] = SBOX[st[4*((c+w)%4)+w]];
      // column mixing except in the last round
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          x = tmp[4*c] ^ tmp[4*c+1] ^ tmp[4*c+2] ^ tmp[4*c+3];
          t0 = tmp[4*c]; t1 = tmp[4*c+1]; t2 = tmp[4*c+2]; t3 = tmp[4*c+3];
          tmp[4*c]   = t0 ^ x ^ gf_dbl(t0 ^ t1);
          tmp[4*c+1] = t1 ^ x ^ gf_dbl(t1 ^ t2);
          tmp[4*c+2] = t2 ^ x ^ gf_dbl(t2 ^ t3);
          tmp[4*c+3] = t3 ^ x ^ gf_dbl(t3 ^ t0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    n_errors++;
  endtask

  // key register write while idle, mirrored in the model copy of the key
  task automatic write_key(cfg_reg_e idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = value;
    else key_lo_q = value;
    @(posedge clk_i);
  endtask

  // send one plaintext word and queue its ciphertext
  // valid stays up so the next word can follow at once
  task automatic send_word(logic [63:0] hi, logic [63:0] lo);
    logic [127:0] ct;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_blk.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_blk.valid     <= 1'b1;
    in_blk.data_high <= hi;
    in_blk.data_low  <= lo;
    do @(posedge clk_i); while (!in_blk.ready);
    ct = encrypt_block({key_hi_q, key_lo_q}, {hi, lo});
    cipher_fifo.push_back('{cipher_high: ct[127:64], cipher_low: ct[63:0]});
  endtask

  task automatic drain();
    in_blk.valid <= 1'b0;
    while (cipher_fifo.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random data with occasional sparse or dense patterns
  task automatic random_words(int unsigned n);
    logic [63:0] a, b;
    for (int unsigned k = 0; k < n; k++) begin
      a = rand64();
      b = rand64();
      case ($urandom_range(7))
        0: a = '0;
        1: b = '1;
        2: begin a = 64'd1 << $urandom_range(63); b = ~(64'd1 << $urandom_range(63)); end
        default: ;
      endcase
      send_word(a, b);
    end
  endtask

  // ciphertext checker
  always @(posedge clk_i) begin
    cipher_word_t exp_w;
    if (rst_ni && out_blk.valid && out_blk.ready) begin
      if (cipher_fifo.size() == 0) begin
        report_mismatch("unexpected word", out_blk.data_high, '0);
      end else begin
        exp_w = cipher_fifo.pop_front();
        if (out_blk.data_high !== exp_w.cipher_high)
          report_mismatch("cipher_high", out_blk.data_high, exp_w.cipher_high);
        if (out_blk.data_low !== exp_w.cipher_low)
          report_mismatch("cipher_low", out_blk.data_low, exp_w.cipher_low);
      end
    end
  end

  // receiver ready
  always @(posedge clk_i) begin
    if (hold_off) out_blk.ready <= 1'b0;
    else out_blk.ready <= (sink_stall == 0) || ($urandom_range(99) >= sink_stall);
  end

  // directed: extremes under the reset key, then standard vectors and extremes under written keys
  task automatic test_directed();
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'h8000000000000000, 64'h0000000000000001);
    drain();
    write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
    send_word(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_word(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    drain();
    write_key(REG_KEY_HIGH, 64'h0001020304050607);
    write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word('0, '1);
    drain();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
  endtask

  task automatic test_idle_mix(int unsigned idle_pct, int unsigned stall_pct,
                               int unsigned n);
    send_idle  = idle_pct;
    sink_stall = stall_pct;
    write_key(REG_KEY_HIGH, rand64());
    write_key(REG_KEY_LOW, rand64());
    random_words(n);
    drain();
  endtask

  // long output hold-off so the pipe fills and input stalls
  task automatic test_backpressure();
    send_idle  = 0;
    sink_stall = 0;
    write_key(REG_KEY_HIGH, '0);
    write_key(REG_KEY_LOW, rand64());
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_words(40);
    join
    drain();
  endtask

  initial begin
    in_blk.valid     = 1'b0;
    in_blk.data_high = '0;
    in_blk.data_low  = '0;
    out_blk.ready    = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = REG_KEY_HIGH;
    cfg.data         = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_mix(0, 0, 400);
    test_idle_mix(48, 0, 350);
    test_idle_mix(0, 48, 350);
    test_idle_mix(16, 16, 400);
    test_backpressure();
    if (n_errors == 0 && cipher_fifo.size() == 0) begin
      $display("tb_aes128_block_encrypt_core: PASS");
    end else begin
      $display("tb_aes128_block_encrypt_core: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_aes128_block_encrypt_core: FAIL");
    $finish;
  end

endmodule
